// ===== rtl/qfr_pkg.sv =====
`default_nettype none
package qfr_pkg;

    // field and parameter widths
    localparam int WIDTH = 32;          // reduced parts must fit this many bits, signed
    localparam int DW    = 32;          // operand and result field width
    localparam int OW    = DW + 2;      // multiplier operand, holds a + 2*b
    localparam int PW    = 2 * OW;      // product width
    localparam int XW    = 72;          // combined sums before the wide multiply
    localparam int AW    = 136;         // wide accumulator, holds a 66-bit square
    localparam int GW    = 100;         // gcd and divide width, holds any arithmetic part
    localparam int KW    = $clog2(GW + 1);
    localparam int NPROD = 7;
    localparam int PIW   = $clog2(NPROD);
    localparam int NLANE = 3;
    localparam int QD    = 2;
    localparam int QAW   = $clog2(QD);
    localparam int QCW   = $clog2(QD + 1);

    localparam logic [GW-1:0] LIM = GW'(1) << (WIDTH - 1);

    // operation codes, equal to the mode field for the known modes
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_CONJ = 3'd4;
    localparam logic [2:0] OP_CMP  = 3'd5;
    localparam logic [2:0] OP_BAD  = 3'd6;

    localparam logic [1:0] ORD_LESS = 2'd0;
    localparam logic [1:0] ORD_EQ   = 2'd1;
    localparam logic [1:0] ORD_GT   = 2'd2;

    typedef struct packed {
        logic [2:0]            op;
        logic signed [DW-1:0]  a;
        logic signed [DW-1:0]  b;
        logic signed [DW-1:0]  c;
        logic signed [DW-1:0]  x;
        logic signed [DW-1:0]  y;
        logic signed [DW-1:0]  z;
        logic signed [OW-1:0]  ab2;     // a + 2*b
        logic signed [OW-1:0]  xy2;     // x + 2*y
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic signed [DW-1:0] res_int;
        logic signed [DW-1:0] res_beta;
        logic signed [DW-1:0] res_den;
        logic [1:0]           order;
        logic                 was_reduced;
        logic                 error_flag;
    } t_res;

    function automatic logic signed [OW-1:0] f_sx(input logic signed [DW-1:0] v);
        return {{(OW-DW){v[DW-1]}}, v};
    endfunction

    function automatic logic signed [XW-1:0] f_xw(input logic signed [DW-1:0] v);
        return {{(XW-DW){v[DW-1]}}, v};
    endfunction

    function automatic logic [XW-1:0] f_abs(input logic signed [XW-1:0] v);
        return v[XW-1] ? ((~v) + XW'(1)) : v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/quadratic_field_rational_alu.sv =====
// Exact arithmetic on (p + q*beta)/d with beta = 2 + sqrt(3).
// Input channel: i_in_valid / o_in_stall carry mode and two operands; a transfer
// happens on a rising edge with valid high and stall low. Output channel:
// o_out_valid / i_out_stall carry one result per item, in item order.
// Modes: add, subtract, multiply, divide, conjugate of the first operand,
// compare (order only). Results are reduced by the gcd of all three parts.
// Structure: an input register classifies the item, a two-entry queue buffers
// it, and a sequential unit computes: a 34x34 multiplier for up to seven
// products, a shift-add multiplier for the wide products and squares, a binary
// gcd stepping once per cycle over 100-bit values, and a restoring divide
// shared by the three parts. The time an item takes is data dependent.
// Items are worked one at a time.
// Reset (synchronous, active low) empties the queue and drops any pending result.
// While the receiver stalls the result holds; the queue keeps taking items
// until it and the input register are full, then o_in_stall rises.
`default_nettype none
module quadratic_field_rational_alu (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [2:0]                     i_mode,
    input  wire logic signed [qfr_pkg::DW-1:0]  i_first_int,
    input  wire logic signed [qfr_pkg::DW-1:0]  i_first_beta,
    input  wire logic signed [qfr_pkg::DW-1:0]  i_first_den,
    input  wire logic signed [qfr_pkg::DW-1:0]  i_second_int,
    input  wire logic signed [qfr_pkg::DW-1:0]  i_second_beta,
    input  wire logic signed [qfr_pkg::DW-1:0]  i_second_den,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic signed [qfr_pkg::DW-1:0]       o_res_int,
    output logic signed [qfr_pkg::DW-1:0]       o_res_beta,
    output logic signed [qfr_pkg::DW-1:0]       o_res_den,
    output logic [1:0]                          o_order,
    output logic                                o_was_reduced,
    output logic                                o_error_flag
);

    qfr_pkg::t_job   w_push_job;
    qfr_pkg::t_job   w_head_job;
    qfr_pkg::t_qstat w_qstat;
    qfr_pkg::t_res   w_res;
    logic            w_push;
    logic            w_pop;

    qfr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_mode  (i_mode),
        .i_a     (i_first_int),
        .i_b     (i_first_beta),
        .i_c     (i_first_den),
        .i_x     (i_second_int),
        .i_y     (i_second_beta),
        .i_z     (i_second_den),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    qfr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_qstat (w_qstat)
    );

    qfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ready (!w_qstat.empty),
        .i_job   (w_head_job),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (w_res)
    );

    assign o_res_int     = w_res.res_int;
    assign o_res_beta    = w_res.res_beta;
    assign o_res_den     = w_res.res_den;
    assign o_order       = w_res.order;
    assign o_was_reduced = w_res.was_reduced;
    assign o_error_flag  = w_res.error_flag;

endmodule
`default_nettype wire

// ===== rtl/qfr_front.sv =====
`default_nettype none
module qfr_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [2:0]                     i_mode,
    input  wire logic signed [qfr_pkg::DW-1:0]  i_a,
    input  wire logic signed [qfr_pkg::DW-1:0]  i_b,
    input  wire logic signed [qfr_pkg::DW-1:0]  i_c,
    input  wire logic signed [qfr_pkg::DW-1:0]  i_x,
    input  wire logic signed [qfr_pkg::DW-1:0]  i_y,
    input  wire logic signed [qfr_pkg::DW-1:0]  i_z,
    input  wire qfr_pkg::t_qstat                i_qstat,
    output logic                                o_push,
    output qfr_pkg::t_job                       o_job
);

    logic          r_valid;
    qfr_pkg::t_job r_job;
    qfr_pkg::t_job n_job;
    logic          w_accept;

    assign o_push   = r_valid && !i_qstat.full;
    assign o_stall  = r_valid && i_qstat.full;
    assign w_accept = i_valid && !o_stall;
    assign o_job    = r_job;

    always_comb begin
        n_job.op  = (i_mode > qfr_pkg::OP_CMP) ? qfr_pkg::OP_BAD : i_mode;
        n_job.a   = i_a;
        n_job.b   = i_b;
        n_job.c   = i_c;
        n_job.x   = i_x;
        n_job.y   = i_y;
        n_job.z   = i_z;
        n_job.ab2 = qfr_pkg::f_sx(i_a) + (qfr_pkg::f_sx(i_b) <<< 1);
        n_job.xy2 = qfr_pkg::f_sx(i_x) + (qfr_pkg::f_sx(i_y) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job <= n_job;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/qfr_fifo.sv =====
`default_nettype none
module qfr_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire qfr_pkg::t_job  i_job,
    input  wire logic           i_pop,
    output qfr_pkg::t_job       o_job,
    output qfr_pkg::t_qstat     o_qstat
);

    qfr_pkg::t_job                r_mem [qfr_pkg::QD];
    logic [qfr_pkg::QAW-1:0]      r_wp;
    logic [qfr_pkg::QAW-1:0]      r_rp;
    logic [qfr_pkg::QCW-1:0]      r_cnt;

    assign o_qstat.full  = (r_cnt == qfr_pkg::QCW'(qfr_pkg::QD));
    assign o_qstat.empty = (r_cnt == '0);
    assign o_job         = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + qfr_pkg::QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + qfr_pkg::QAW'(1);
            end
            r_cnt <= r_cnt + qfr_pkg::QCW'(i_push) - qfr_pkg::QCW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/qfr_back.sv =====
`default_nettype none
module qfr_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_ready,
    input  wire qfr_pkg::t_job  i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_stall,
    output qfr_pkg::t_res       o_res
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PROD = 4'd1;
    localparam logic [3:0] ST_COMB = 4'd2;
    localparam logic [3:0] ST_MUL  = 4'd3;
    localparam logic [3:0] ST_CMP  = 4'd4;
    localparam logic [3:0] ST_GCD  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_FIT  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    localparam int CW = qfr_pkg::AW + 3;

    logic [3:0]                        r_st;
    qfr_pkg::t_job                     r_job;
    logic [qfr_pkg::PIW-1:0]           r_pi;
    logic signed [qfr_pkg::PW-1:0]     r_t   [qfr_pkg::NPROD];
    logic [qfr_pkg::AW-1:0]            r_mc  [qfr_pkg::NLANE];
    logic [qfr_pkg::XW-1:0]            r_mp  [qfr_pkg::NLANE];
    logic [qfr_pkg::AW-1:0]            r_acc [qfr_pkg::NLANE];
    logic                              r_sg  [qfr_pkg::NLANE];
    logic [qfr_pkg::GW-1:0]            r_n   [qfr_pkg::NLANE];
    logic [qfr_pkg::GW-1:0]            r_rem [qfr_pkg::NLANE];
    logic [qfr_pkg::GW-1:0]            r_u;
    logic [qfr_pkg::GW-1:0]            r_v;
    logic [qfr_pkg::GW-1:0]            r_g;
    logic [qfr_pkg::KW-1:0]            r_k;
    logic                              r_gph;
    logic [qfr_pkg::KW-1:0]            r_dc;
    logic                              r_red;
    qfr_pkg::t_res                     r_res;
    qfr_pkg::t_res                     r_out;
    logic                              r_oval;

    logic signed [qfr_pkg::OW-1:0]     m_x;
    logic signed [qfr_pkg::OW-1:0]     m_y;
    logic signed [qfr_pkg::PW-1:0]     m_prod;
    logic [qfr_pkg::PIW-1:0]           w_last;
    logic signed [qfr_pkg::XW-1:0]     w_t [qfr_pkg::NPROD];
    logic signed [qfr_pkg::XW-1:0]     v_p, v_q, v_d, v_mp, v_mq, v_md, v_norm;
    logic                              w_mul_done;
    logic [qfr_pkg::GW-1:0]            w_gfin;
    logic                              w_fit;
    logic signed [CW-1:0]              w_lhs;
    logic signed [CW-1:0]              w_rhs;
    logic [qfr_pkg::AW+1:0]            w_r3;
    logic                              w_out_load;

    assign o_pop      = (r_st == ST_IDLE) && i_ready;
    assign o_valid    = r_oval;
    assign o_res      = r_out;
    assign w_out_load = (r_st == ST_OUT) && (!r_oval || !i_stall);
    assign m_prod     = m_x * m_y;

    // operand pairs for the product sequence, per operation
    always_comb begin
        m_x    = qfr_pkg::f_sx(r_job.z);
        m_y    = qfr_pkg::f_sx(r_job.c);
        w_last = qfr_pkg::PIW'(4);
        unique case (r_job.op)
            qfr_pkg::OP_ADD, qfr_pkg::OP_SUB: begin
                unique case (r_pi)
                    3'd0: begin m_x = qfr_pkg::f_sx(r_job.a); m_y = qfr_pkg::f_sx(r_job.z); end
                    3'd1: begin m_x = qfr_pkg::f_sx(r_job.x); m_y = qfr_pkg::f_sx(r_job.c); end
                    3'd2: begin m_x = qfr_pkg::f_sx(r_job.b); m_y = qfr_pkg::f_sx(r_job.z); end
                    3'd3: begin m_x = qfr_pkg::f_sx(r_job.y); m_y = qfr_pkg::f_sx(r_job.c); end
                    default: ;
                endcase
            end
            qfr_pkg::OP_MUL: begin
                unique case (r_pi)
                    3'd0: begin m_x = qfr_pkg::f_sx(r_job.a); m_y = qfr_pkg::f_sx(r_job.x); end
                    3'd1: begin m_x = qfr_pkg::f_sx(r_job.b); m_y = qfr_pkg::f_sx(r_job.y); end
                    3'd2: begin m_x = qfr_pkg::f_sx(r_job.b); m_y = qfr_pkg::f_sx(r_job.x); end
                    3'd3: begin m_x = qfr_pkg::f_sx(r_job.a); m_y = qfr_pkg::f_sx(r_job.y); end
                    default: ;
                endcase
            end
            qfr_pkg::OP_DIV: begin
                w_last = qfr_pkg::PIW'(6);
                unique case (r_pi)
                    3'd0: begin m_x = qfr_pkg::f_sx(r_job.a); m_y = qfr_pkg::f_sx(r_job.x); end
                    3'd1: begin m_x = qfr_pkg::f_sx(r_job.b); m_y = qfr_pkg::f_sx(r_job.y); end
                    3'd2: begin m_x = qfr_pkg::f_sx(r_job.a); m_y = qfr_pkg::f_sx(r_job.y); end
                    3'd3: begin m_x = qfr_pkg::f_sx(r_job.b); m_y = qfr_pkg::f_sx(r_job.x); end
                    3'd4: begin m_x = qfr_pkg::f_sx(r_job.x); m_y = qfr_pkg::f_sx(r_job.x); end
                    3'd5: begin m_x = qfr_pkg::f_sx(r_job.x); m_y = qfr_pkg::f_sx(r_job.y); end
                    default: begin
                        m_x = qfr_pkg::f_sx(r_job.y); m_y = qfr_pkg::f_sx(r_job.y);
                    end
                endcase
            end
            qfr_pkg::OP_CMP: begin
                w_last = qfr_pkg::PIW'(3);
                unique case (r_pi)
                    3'd0: begin m_x = r_job.ab2; m_y = qfr_pkg::f_sx(r_job.z); end
                    3'd1: begin m_x = r_job.xy2; m_y = qfr_pkg::f_sx(r_job.c); end
                    3'd2: begin m_x = qfr_pkg::f_sx(r_job.y); m_y = qfr_pkg::f_sx(r_job.c); end
                    default: begin
                        m_x = qfr_pkg::f_sx(r_job.b); m_y = qfr_pkg::f_sx(r_job.z);
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int i = 0; i < qfr_pkg::NPROD; i++) begin
            w_t[i] = {{(qfr_pkg::XW-qfr_pkg::PW){r_t[i][qfr_pkg::PW-1]}}, r_t[i]};
        end
    end

    // numerators, denominator and their late factors; compare puts L and R in p and q
    always_comb begin
        v_p    = '0;
        v_q    = '0;
        v_d    = w_t[4];
        v_mp   = qfr_pkg::XW'(1);
        v_mq   = qfr_pkg::XW'(1);
        v_md   = qfr_pkg::XW'(1);
        v_norm = w_t[4] + (w_t[5] <<< 2) + w_t[6];
        unique case (r_job.op)
            qfr_pkg::OP_ADD: begin
                v_p = w_t[0] + w_t[1];
                v_q = w_t[2] + w_t[3];
            end
            qfr_pkg::OP_SUB: begin
                v_p = w_t[0] - w_t[1];
                v_q = w_t[2] - w_t[3];
            end
            qfr_pkg::OP_MUL: begin
                v_p = w_t[0] - w_t[1];
                v_q = w_t[2] + w_t[3] + (w_t[1] <<< 2);
            end
            qfr_pkg::OP_DIV: begin
                v_p  = w_t[0] + w_t[1] + (w_t[2] <<< 2);
                v_q  = w_t[3] - w_t[2];
                v_d  = v_norm;
                v_mp = qfr_pkg::f_xw(r_job.z);
                v_mq = qfr_pkg::f_xw(r_job.z);
                v_md = qfr_pkg::f_xw(r_job.c);
            end
            qfr_pkg::OP_CONJ: begin
                v_p = qfr_pkg::f_xw(r_job.a) + (qfr_pkg::f_xw(r_job.b) <<< 2);
                v_q = -qfr_pkg::f_xw(r_job.b);
                v_d = qfr_pkg::f_xw(r_job.c);
            end
            qfr_pkg::OP_CMP: begin
                v_p = w_t[0] - w_t[1];
                v_q = w_t[2] - w_t[3];
            end
            default: ;
        endcase
    end

    always_comb begin
        w_mul_done = 1'b1;
        for (int i = 0; i < qfr_pkg::NLANE; i++) begin
            if (r_mp[i] != '0) begin
                w_mul_done = 1'b0;
            end
        end
    end

    assign w_gfin = (r_u | r_v) << r_k;

    // sign(L)*L^2 against 3*sign(R)*R^2
    assign w_r3  = {2'b00, r_acc[1]} + {1'b0, r_acc[1], 1'b0};
    assign w_lhs = r_sg[0] ? -$signed({3'b000, r_acc[0]}) : $signed({3'b000, r_acc[0]});
    assign w_rhs = r_sg[1] ? -$signed({1'b0, w_r3}) : $signed({1'b0, w_r3});

    always_comb begin
        w_fit = 1'b1;
        for (int i = 0; i < qfr_pkg::NLANE; i++) begin
            if (!(r_n[i] < qfr_pkg::LIM || (r_sg[i] && r_n[i] == qfr_pkg::LIM))) begin
                w_fit = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            unique case (r_st)
                ST_IDLE: begin
                    if (i_ready) begin
                        if (i_job.op == qfr_pkg::OP_BAD) begin
                            r_st <= ST_OUT;
                        end else if (i_job.op == qfr_pkg::OP_CONJ) begin
                            r_st <= ST_COMB;
                        end else begin
                            r_st <= ST_PROD;
                        end
                    end
                end
                ST_PROD: begin
                    if (r_pi == w_last) begin
                        r_st <= ST_COMB;
                    end
                end
                ST_COMB: begin
                    if (r_job.op == qfr_pkg::OP_DIV && v_norm == '0) begin
                        r_st <= ST_OUT;
                    end else begin
                        r_st <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (w_mul_done) begin
                        if (r_job.op == qfr_pkg::OP_CMP) begin
                            r_st <= ST_CMP;
                        end else if (r_acc[0][qfr_pkg::GW-1:0] == '0
                                     && r_acc[1][qfr_pkg::GW-1:0] == '0) begin
                            r_st <= ST_FIT;
                        end else begin
                            r_st <= ST_GCD;
                        end
                    end
                end
                ST_CMP: r_st <= ST_OUT;
                ST_GCD: begin
                    if ((r_u == '0 || r_v == '0) && r_gph) begin
                        r_st <= (w_gfin > qfr_pkg::GW'(1)) ? ST_DIV : ST_FIT;
                    end
                end
                ST_DIV: begin
                    if (r_dc == '0) begin
                        r_st <= ST_FIT;
                    end
                end
                ST_FIT: r_st <= ST_OUT;
                ST_OUT: begin
                    if (w_out_load) begin
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        logic [qfr_pkg::GW:0] trial;
        unique case (r_st)
            ST_IDLE: begin
                r_job             <= i_job;
                r_pi              <= '0;
                r_red             <= 1'b0;
                r_res.res_int     <= '0;
                r_res.res_beta    <= '0;
                r_res.res_den     <= '0;
                r_res.order       <= qfr_pkg::ORD_LESS;
                r_res.was_reduced <= 1'b0;
                r_res.error_flag  <= (i_job.op == qfr_pkg::OP_BAD);
            end
            ST_PROD: begin
                r_t[r_pi] <= m_prod;
                r_pi      <= r_pi + qfr_pkg::PIW'(1);
            end
            ST_COMB: begin
                if (r_job.op == qfr_pkg::OP_DIV && v_norm == '0) begin
                    r_res.error_flag <= 1'b1;
                end
                for (int i = 0; i < qfr_pkg::NLANE; i++) begin
                    r_acc[i] <= '0;
                end
                if (r_job.op == qfr_pkg::OP_CMP) begin
                    r_mc[0] <= qfr_pkg::AW'(qfr_pkg::f_abs(v_p));
                    r_mp[0] <= qfr_pkg::f_abs(v_p);
                    r_sg[0] <= v_p[qfr_pkg::XW-1];
                    r_mc[1] <= qfr_pkg::AW'(qfr_pkg::f_abs(v_q));
                    r_mp[1] <= qfr_pkg::f_abs(v_q);
                    r_sg[1] <= v_q[qfr_pkg::XW-1];
                    r_mc[2] <= '0;
                    r_mp[2] <= '0;
                    r_sg[2] <= 1'b0;
                end else begin
                    r_mc[0] <= qfr_pkg::AW'(qfr_pkg::f_abs(v_p));
                    r_mp[0] <= qfr_pkg::f_abs(v_mp);
                    r_sg[0] <= v_p[qfr_pkg::XW-1] ^ v_mp[qfr_pkg::XW-1];
                    r_mc[1] <= qfr_pkg::AW'(qfr_pkg::f_abs(v_q));
                    r_mp[1] <= qfr_pkg::f_abs(v_mq);
                    r_sg[1] <= v_q[qfr_pkg::XW-1] ^ v_mq[qfr_pkg::XW-1];
                    r_mc[2] <= qfr_pkg::AW'(qfr_pkg::f_abs(v_d));
                    r_mp[2] <= qfr_pkg::f_abs(v_md);
                    r_sg[2] <= v_d[qfr_pkg::XW-1] ^ v_md[qfr_pkg::XW-1];
                end
            end
            ST_MUL: begin
                if (w_mul_done) begin
                    for (int i = 0; i < qfr_pkg::NLANE; i++) begin
                        r_n[i] <= r_acc[i][qfr_pkg::GW-1:0];
                    end
                    r_u   <= r_acc[0][qfr_pkg::GW-1:0];
                    r_v   <= r_acc[1][qfr_pkg::GW-1:0];
                    r_k   <= '0;
                    r_gph <= 1'b0;
                end else begin
                    for (int i = 0; i < qfr_pkg::NLANE; i++) begin
                        if (r_mp[i][0]) begin
                            r_acc[i] <= r_acc[i] + r_mc[i];
                        end
                        r_mc[i] <= r_mc[i] << 1;
                        r_mp[i] <= r_mp[i] >> 1;
                    end
                end
            end
            ST_CMP: begin
                if (w_lhs < w_rhs) begin
                    r_res.order <= qfr_pkg::ORD_LESS;
                end else if (w_lhs > w_rhs) begin
                    r_res.order <= qfr_pkg::ORD_GT;
                end else begin
                    r_res.order <= qfr_pkg::ORD_EQ;
                end
            end
            ST_GCD: begin
                // binary gcd, one step a cycle; second pass folds in the denominator
                if (r_u == '0 || r_v == '0) begin
                    if (!r_gph) begin
                        r_u   <= w_gfin;
                        r_v   <= r_n[2];
                        r_k   <= '0;
                        r_gph <= 1'b1;
                    end else begin
                        r_g  <= w_gfin;
                        r_dc <= qfr_pkg::KW'(qfr_pkg::GW - 1);
                        for (int i = 0; i < qfr_pkg::NLANE; i++) begin
                            r_rem[i] <= '0;
                        end
                    end
                end else if (!r_u[0] && !r_v[0]) begin
                    r_u <= r_u >> 1;
                    r_v <= r_v >> 1;
                    r_k <= r_k + qfr_pkg::KW'(1);
                end else if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (r_u >= r_v) begin
                    r_u <= (r_u - r_v) >> 1;
                end else begin
                    r_v <= (r_v - r_u) >> 1;
                end
            end
            ST_DIV: begin
                r_red <= 1'b1;
                for (int i = 0; i < qfr_pkg::NLANE; i++) begin
                    trial = {r_rem[i], r_n[i][qfr_pkg::GW-1]};
                    if (trial >= {1'b0, r_g}) begin
                        r_rem[i] <= qfr_pkg::GW'(trial - {1'b0, r_g});
                        r_n[i]   <= {r_n[i][qfr_pkg::GW-2:0], 1'b1};
                    end else begin
                        r_rem[i] <= trial[qfr_pkg::GW-1:0];
                        r_n[i]   <= {r_n[i][qfr_pkg::GW-2:0], 1'b0};
                    end
                end
                r_dc <= r_dc - qfr_pkg::KW'(1);
            end
            ST_FIT: begin
                if (w_fit) begin
                    r_res.res_int     <= r_sg[0] ? -r_n[0][qfr_pkg::DW-1:0]
                                                 : r_n[0][qfr_pkg::DW-1:0];
                    r_res.res_beta    <= r_sg[1] ? -r_n[1][qfr_pkg::DW-1:0]
                                                 : r_n[1][qfr_pkg::DW-1:0];
                    r_res.res_den     <= r_sg[2] ? -r_n[2][qfr_pkg::DW-1:0]
                                                 : r_n[2][qfr_pkg::DW-1:0];
                    r_res.was_reduced <= r_red;
                end else begin
                    r_res.error_flag <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (w_out_load) begin
            r_oval <= 1'b1;
        end else if (!i_stall) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= r_res;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/qfr_checker.sv =====
`default_nettype none
module qfr_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire logic signed [qfr_pkg::DW-1:0]  o_res_int,
    input wire logic signed [qfr_pkg::DW-1:0]  o_res_beta,
    input wire logic signed [qfr_pkg::DW-1:0]  o_res_den,
    input wire logic [1:0]                     o_order,
    input wire logic                           o_was_reduced,
    input wire logic                           o_error_flag
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_res_int) && $stable(o_res_den)
            && $stable(o_order) && $stable(o_error_flag))
        else $error("stalled result changed");

    // an error result carries nothing else
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_flag |-> o_res_int == '0 && o_res_beta == '0
            && o_res_den == '0 && !o_was_reduced && o_order == qfr_pkg::ORD_LESS)
        else $error("error result has nonzero fields");

    // a nonzero order only comes from compare, which leaves the parts zero
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_order != qfr_pkg::ORD_LESS |-> o_order != 2'd3
            && o_res_int == '0 && o_res_beta == '0 && o_res_den == '0
            && !o_was_reduced && !o_error_flag)
        else $error("bad compare result");

endmodule

bind quadratic_field_rational_alu qfr_checker u_qfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_res_int     (o_res_int),
    .o_res_beta    (o_res_beta),
    .o_res_den     (o_res_den),
    .o_order       (o_order),
    .o_was_reduced (o_was_reduced),
    .o_error_flag  (o_error_flag)
);
`default_nettype wire
